// ----- hdl/tcc_pkg.sv -----
// tcc_pkg: shared types and constants for the touch click classifier
// holds the event codes, register indexes, limit reset values and the limit struct
// no dependencies
`default_nettype none

package tcc_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LIMIT_W = 8;
    localparam int unsigned INDEX_W = 2;

    typedef enum logic [1:0] {
        EV_IDLE   = 2'd0,
        EV_SHORT  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    typedef enum logic [INDEX_W-1:0] {
        REG_SHORT_LIMIT   = 2'd0,
        REG_DOUBLE_WINDOW = 2'd1,
        REG_LONG_LIMIT    = 2'd2
    } reg_index_t;

    localparam logic [LIMIT_W-1:0] SHORT_LIMIT_RST   = 8'd200;
    localparam logic [LIMIT_W-1:0] DOUBLE_WINDOW_RST = 8'd250;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST    = 8'd255;

    typedef struct packed {
        logic [LIMIT_W-1:0] short_limit_ms;
        logic [LIMIT_W-1:0] double_window_ms;
        logic [LIMIT_W-1:0] long_limit_ms;
    } limits_t;

endpackage

`default_nettype wire

// ----- hdl/tcc_core.sv -----
// tcc_core: key state, timestamps, pending flags and per-poll event selection
// one poll is classified combinationally and the state advances on step
// depends on tcc_pkg
`default_nettype none

module tcc_core
    import tcc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic              level,
    input  wire logic [TIME_W-1:0] now,
    input  wire limits_t           limits,
    output event_t                 ev
);

    logic              is_pressed_reg,     is_pressed_next;
    logic [TIME_W-1:0] press_time_reg,     press_time_next;
    logic [TIME_W-1:0] release_time_reg,   release_time_next;
    logic [TIME_W-1:0] click_time_reg,     click_time_next;
    logic [TIME_W-1:0] double_time_reg,    double_time_next;
    logic              click_pending_reg,  click_pending_next;
    logic              double_pending_reg, double_pending_next;
    logic              long_pending_reg,   long_pending_next;

    logic [TIME_W-1:0]  hold;
    logic [TIME_W-1:0]  since_click;
    logic [TIME_W-1:0]  since_double;
    logic [TIME_W-1:0]  since_release;
    logic [LIMIT_W:0]   limit_sum;
    logic               release_edge;
    logic               click_pend_mid;
    logic               double_pend_mid;
    logic               long_pend_mid;

    assign release_edge  = !level && is_pressed_reg;
    assign hold          = now - press_time_reg;
    assign since_click   = now - click_time_reg;
    assign since_double  = now - double_time_reg;
    assign limit_sum     = {1'b0, limits.short_limit_ms} + {1'b0, limits.double_window_ms};

    always_comb
    begin
        is_pressed_next   = is_pressed_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        click_time_next   = click_time_reg;
        double_time_next  = double_time_reg;
        click_pend_mid    = click_pending_reg;
        double_pend_mid   = double_pending_reg;
        long_pend_mid     = long_pending_reg;

        if (level && !is_pressed_reg)
        begin
            press_time_next = now;
            is_pressed_next = 1'b1;
        end
        else if (release_edge)
        begin
            release_time_next = now;
            is_pressed_next   = 1'b0;
            if (hold <= TIME_W'(limits.short_limit_ms))
            begin
                if (since_click <= TIME_W'(limits.double_window_ms) &&
                    since_double > TIME_W'(limit_sum))
                begin
                    double_pend_mid  = 1'b1;
                    double_time_next = now;
                end
                click_pend_mid  = 1'b1;
                click_time_next = now;
            end
            else if (hold >= TIME_W'(limits.long_limit_ms))
            begin
                long_pend_mid = 1'b1;
            end
        end

        since_release = now - release_time_next;

        click_pending_next  = click_pend_mid;
        double_pending_next = double_pend_mid;
        long_pending_next   = long_pend_mid;

        priority if (click_pend_mid && double_pend_mid)
        begin
            ev                  = EV_DOUBLE;
            click_pending_next  = 1'b0;
            double_pending_next = 1'b0;
        end
        else if (click_pend_mid && since_release > TIME_W'(limits.double_window_ms))
        begin
            ev                 = EV_SHORT;
            click_pending_next = 1'b0;
        end
        else if (long_pend_mid)
        begin
            ev                = EV_LONG;
            long_pending_next = 1'b0;
        end
        else
        begin
            ev = EV_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_pressed_reg     <= 1'b0;
            press_time_reg     <= '0;
            release_time_reg   <= '0;
            click_time_reg     <= '0;
            double_time_reg    <= '0;
            click_pending_reg  <= 1'b0;
            double_pending_reg <= 1'b0;
            long_pending_reg   <= 1'b0;
        end
        else if (step)
        begin
            is_pressed_reg     <= is_pressed_next;
            press_time_reg     <= press_time_next;
            release_time_reg   <= release_time_next;
            click_time_reg     <= click_time_next;
            double_time_reg    <= double_time_next;
            click_pending_reg  <= click_pending_next;
            double_pending_reg <= double_pending_next;
            long_pending_reg   <= long_pending_next;
        end
    end

`ifndef SYNTHESIS
    a_press_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        step && level |=> is_pressed_reg)
        else $error("key not marked pressed after touched poll");

    a_release_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        step && !level |=> !is_pressed_reg)
        else $error("key still marked pressed after released poll");

    a_double_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && ev == EV_DOUBLE |=> !click_pending_reg && !double_pending_reg)
        else $error("pending flags left after double click");

    a_long_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && ev == EV_LONG |=> !long_pending_reg)
        else $error("long pending left after long click");

    a_double_needs_click: assert property (@(posedge clk) disable iff (!rst_n)
        double_pending_reg |-> click_pending_reg)
        else $error("double pending without click pending");
`endif

endmodule

`default_nettype wire

// ----- hdl/touch_click_classifier_unit.sv -----
// touch_click_classifier_unit: top level of the touch click classifier
// input register, limit registers, result register around tcc_core
// depends on tcc_pkg and tcc_core
//
// usage
//   each request on the input channel is one poll of the key: touch_level and
//   time_now in ms. every poll gives exactly one event_code on the output
//   channel: idle, short click, double click or long click.
//   limits are written through the cfg channel (index 0 short limit, 1 double
//   window, 2 long limit, index 3 ignored); cfg_ready is always high and
//   writes are meant for idle periods only.
//   path: a request lands in the input register and is then classified
//   into the result register.
//   throughput: one poll per cycle while the result side does not stall; the
//   classify logic is a handful of 32-bit subtract and compare paths, so a poll
//   finishes in the cycle it leaves the input register.
//   stall: while out_ready is low the result register holds and the input
//   register keeps one more poll; in_ready drops only when both are full.
//   reset: limits return to 200, 250 and 255 ms, key released, all
//   timestamps zero, no pending events, both stages empty.
`default_nettype none

module touch_click_classifier_unit
    import tcc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               touch_level,
    input  wire logic [TIME_W-1:0]  time_now,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [1:0]              event_code,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [LIMIT_W-1:0] cfg_data
);

    logic              in_valid_reg;
    logic              level_reg;
    logic [TIME_W-1:0] time_reg;
    logic              out_valid_reg;
    event_t            event_reg;
    limits_t           limits_reg;
    logic              step;
    logic              out_free;
    event_t            ev;

    assign out_free  = !out_valid_reg || out_ready;
    assign step      = in_valid_reg && out_free;
    assign in_ready  = !in_valid_reg || out_free;
    assign cfg_ready = 1'b1;

    assign out_valid  = out_valid_reg;
    assign event_code = event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.short_limit_ms   <= SHORT_LIMIT_RST;
            limits_reg.double_window_ms <= DOUBLE_WINDOW_RST;
            limits_reg.long_limit_ms    <= LONG_LIMIT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SHORT_LIMIT:   limits_reg.short_limit_ms   <= cfg_data;
                REG_DOUBLE_WINDOW: limits_reg.double_window_ms <= cfg_data;
                REG_LONG_LIMIT:    limits_reg.long_limit_ms    <= cfg_data;
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= step;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            level_reg <= touch_level;
            time_reg  <= time_now;
        end
        if (step)
        begin
            event_reg <= ev;
        end
    end

    tcc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .level  (level_reg),
        .now    (time_reg),
        .limits (limits_reg),
        .ev     (ev)
    );

endmodule

`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// tb_top: self-checking testbench for touch_click_classifier_unit
// drives key polls and limit writes, predicts each event code and checks every result
// depends on tcc_pkg and touch_click_classifier_unit
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tcc_pkg::*;

    localparam logic [INDEX_W-1:0] REG_SPARE = 2'd3;
    localparam int unsigned STALL_LIMIT     = 4000;
    localparam int unsigned DRAIN_CYCLES    = 8;
    localparam int unsigned ITEMS_PER_PHASE = 310;
    localparam int unsigned PHASES          = 6;
    localparam int unsigned PRINT_LIMIT     = 100;

    class click_event_tracker;
        limits_t           limits;
        logic              pressed;
        logic [TIME_W-1:0] press_ms;
        logic [TIME_W-1:0] release_ms;
        logic [TIME_W-1:0] click_ms;
        logic [TIME_W-1:0] double_ms;
        logic              click_pend;
        logic              double_pend;
        logic              long_pend;
        event_t            expected_events[$];
        int unsigned       mismatches;
        int unsigned       checked;
        int unsigned       seen_kind[4];

        function new();
            limits.short_limit_ms   = SHORT_LIMIT_RST;
            limits.double_window_ms = DOUBLE_WINDOW_RST;
            limits.long_limit_ms    = LONG_LIMIT_RST;
            pressed     = 1'b0;
            press_ms    = '0;
            release_ms  = '0;
            click_ms    = '0;
            double_ms   = '0;
            click_pend  = 1'b0;
            double_pend = 1'b0;
            long_pend   = 1'b0;
            mismatches  = 0;
            checked     = 0;
            foreach (seen_kind[k])
                seen_kind[k] = 0;
        endfunction

        function void set_limit(logic [INDEX_W-1:0] index, logic [LIMIT_W-1:0] data);
            case (index)
                REG_SHORT_LIMIT:   limits.short_limit_ms = data;
                REG_DOUBLE_WINDOW: limits.double_window_ms = data;
                REG_LONG_LIMIT:    limits.long_limit_ms = data;
                default: ;
            endcase
        endfunction

        function event_t classify_poll(logic level, logic [TIME_W-1:0] now);
            logic [TIME_W-1:0] hold;
            logic [8:0]        window_sum;
            event_t            ev;
            if (level)
            begin
                if (!pressed)
                begin
                    press_ms = now;
                    pressed  = 1'b1;
                end
            end
            else if (pressed)
            begin
                release_ms = now;
                hold       = now - press_ms;
                window_sum = {1'b0, limits.short_limit_ms} + {1'b0, limits.double_window_ms};
                if (hold <= limits.short_limit_ms)
                begin
                    if ((now - click_ms) <= limits.double_window_ms &&
                        (now - double_ms) > window_sum)
                    begin
                        double_pend = 1'b1;
                        double_ms   = now;
                    end
                    click_pend = 1'b1;
                    click_ms   = now;
                end
                else if (hold >= limits.long_limit_ms)
                begin
                    long_pend = 1'b1;
                end
                pressed = 1'b0;
            end
            if (click_pend && double_pend)
            begin
                ev          = EV_DOUBLE;
                click_pend  = 1'b0;
                double_pend = 1'b0;
            end
            else if (click_pend && (now - release_ms) > limits.double_window_ms)
            begin
                ev         = EV_SHORT;
                click_pend = 1'b0;
            end
            else if (long_pend)
            begin
                ev        = EV_LONG;
                long_pend = 1'b0;
            end
            else
            begin
                ev = EV_IDLE;
            end
            return ev;
        endfunction

        function void note_poll(logic level, logic [TIME_W-1:0] now);
            event_t ev;
            ev = classify_poll(level, now);
            expected_events.push_back(ev);
            seen_kind[ev]++;
        endfunction

        task report_mismatch(string msg);
            if (mismatches < PRINT_LIMIT)
                $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_event(logic [1:0] code);
            event_t want;
            checked++;
            if (expected_events.size() == 0)
            begin
                report_mismatch($sformatf("event_code %0d with no poll outstanding", code));
            end
            else
            begin
                want = expected_events.pop_front();
                if (code !== want)
                    report_mismatch($sformatf("event_code %0d, expected %0d (%s)",
                                              code, want, want.name()));
            end
        endtask

        function int unsigned pending();
            return expected_events.size();
        endfunction
    endclass

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               touch_level = 1'b0;
    logic [TIME_W-1:0]  time_now    = '0;
    logic               out_ready   = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic [INDEX_W-1:0] cfg_index   = '0;
    logic [LIMIT_W-1:0] cfg_data    = '0;
    logic               in_ready;
    logic               out_valid;
    logic               cfg_ready;
    logic [1:0]         event_code;

    click_event_tracker tracker = new();

    int unsigned       src_idle_pct  = 36;
    int unsigned       sink_idle_pct = 53;
    int unsigned       polls_sent    = 0;
    int unsigned       results_seen  = 0;
    int unsigned       quiet_cycles  = 0;
    int unsigned       hold_left     = 0;
    logic              held_once     = 1'b0;
    logic [TIME_W-1:0] clock_ms      = '0;

    touch_click_classifier_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .touch_level (touch_level),
        .time_now    (time_now),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_code  (event_code),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // monitor: limit writes, accepted polls, results and the stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tracker.set_limit(cfg_index, cfg_data);
            if (in_valid && in_ready)
                tracker.note_poll(touch_level, time_now);
            if (out_valid && out_ready)
            begin
                tracker.check_event(event_code);
                results_seen++;
            end
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= STALL_LIMIT)
                begin
                    $display("no request moved for %0d cycles", STALL_LIMIT);
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // result side, with one long hold-off so the block backs up
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!held_once && results_seen >= 600)
        begin
            held_once = 1'b1;
            hold_left = 299;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task send_poll(input logic level, input logic [TIME_W-1:0] stamp);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        touch_level <= level;
        time_now    <= stamp;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        polls_sent++;
        @(negedge clk);
    endtask

    task settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task write_limit(input logic [INDEX_W-1:0] index, input logic [LIMIT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task set_limits(input logic [LIMIT_W-1:0] s, input logic [LIMIT_W-1:0] d,
                    input logic [LIMIT_W-1:0] l);
        write_limit(REG_SHORT_LIMIT, s);
        write_limit(REG_DOUBLE_WINDOW, d);
        write_limit(REG_LONG_LIMIT, l);
    endtask

    function int unsigned near_value(int unsigned centre);
        int v;
        v = int'(centre) + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        return v;
    endfunction

    // press, optional repeated touched polls, release, a few released polls, then a gap
    task click_burst();
        int unsigned       hold;
        int unsigned       extra;
        int unsigned       k;
        int unsigned       gap;
        logic [TIME_W-1:0] start_ms;
        case ($urandom_range(5))
            0:       hold = near_value(tracker.limits.short_limit_ms);
            1:       hold = near_value(tracker.limits.long_limit_ms);
            2:       hold = $urandom_range(320);
            default: hold = $urandom_range(tracker.limits.short_limit_ms);
        endcase
        start_ms = clock_ms;
        send_poll(1'b1, start_ms);
        extra = $urandom_range(2);
        for (k = 1; k <= extra; k++)
            send_poll(1'b1, start_ms + hold * k / (extra + 1));
        clock_ms = start_ms + hold;
        send_poll(1'b0, clock_ms);
        extra = $urandom_range(3);
        for (k = 0; k < extra; k++)
        begin
            clock_ms += $urandom_range(tracker.limits.double_window_ms + 20);
            send_poll(1'b0, clock_ms);
        end
        if ($urandom_range(1))
            gap = $urandom_range(tracker.limits.double_window_ms / 2);
        else
            gap = tracker.limits.double_window_ms + $urandom_range(300);
        clock_ms += gap;
    endtask

    // out-of-pattern polls: random times, time going backwards, repeats, near wrap
    task stray_poll();
        logic level;
        level = 1'($urandom_range(1));
        case ($urandom_range(3))
            0:
            begin
                clock_ms = $urandom();
                send_poll(level, clock_ms);
            end
            1:       send_poll(level, clock_ms - $urandom_range(2000, 1));
            2:       send_poll(level, clock_ms);
            default:
            begin
                clock_ms = 32'hFFFF_FFFF - $urandom_range(600);
                send_poll(level, clock_ms);
            end
        endcase
    endtask

    task apply_setting(input int unsigned phase_no);
        case (phase_no)
            1:
            begin
                set_limits(8'd0, 8'd0, 8'd0);
                write_limit(REG_SPARE, 8'($urandom()));
            end
            2:       set_limits(8'd255, 8'd255, 8'd255);
            3:       set_limits(8'd255, 8'd255, 8'd0);
            4:       set_limits(8'd20, 8'd40, 8'd60);
            default: set_limits(8'($urandom()), 8'($urandom()), 8'($urandom()));
        endcase
    endtask

    initial
    begin
        int unsigned phase_no;
        int unsigned target;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed polls on the reset limits
        send_poll(1'b0, 32'd0);
        send_poll(1'b1, 32'd1000);
        send_poll(1'b0, 32'd1100);
        send_poll(1'b0, 32'd1400);
        send_poll(1'b1, 32'd2000);
        send_poll(1'b0, 32'd2050);
        send_poll(1'b1, 32'd2100);
        send_poll(1'b0, 32'd2150);
        send_poll(1'b1, 32'd2200);
        send_poll(1'b0, 32'd2250);
        send_poll(1'b0, 32'd2600);
        send_poll(1'b1, 32'd3000);
        send_poll(1'b0, 32'd3200);
        send_poll(1'b0, 32'd3451);
        send_poll(1'b1, 32'd4000);
        send_poll(1'b0, 32'd4255);
        send_poll(1'b1, 32'd5000);
        send_poll(1'b0, 32'd5230);
        send_poll(1'b1, 32'hFFFF_FFF0);
        send_poll(1'b0, 32'h0000_0040);
        send_poll(1'b0, 32'h0000_0200);
        send_poll(1'b1, 32'h0000_1000);
        send_poll(1'b0, 32'h0000_0800);
        send_poll(1'b1, 32'hFFFF_FFFF);
        send_poll(1'b0, 32'hFFFF_FFFF);
        clock_ms = 32'd10000;

        for (phase_no = 0; phase_no < PHASES; phase_no++)
        begin
            if (phase_no == 2)
            begin
                src_idle_pct  = 53;
                sink_idle_pct = 36;
            end
            else if (phase_no == 4)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            if (phase_no != 0)
            begin
                settle();
                apply_setting(phase_no);
            end
            target = polls_sent + ITEMS_PER_PHASE;
            while (polls_sent < target)
            begin
                if ($urandom_range(99) < 85)
                    click_burst();
                else
                    stray_poll();
            end
        end
        settle();

        $display("%0d polls over %0d limit settings, %0d results checked",
                 polls_sent, PHASES, tracker.checked);
        $display("predicted events: %0d idle, %0d short, %0d double, %0d long",
                 tracker.seen_kind[EV_IDLE], tracker.seen_kind[EV_SHORT],
                 tracker.seen_kind[EV_DOUBLE], tracker.seen_kind[EV_LONG]);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
